FILE: hdl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// shared types and constants of the portable file-name checker
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 9;
  localparam int unsigned StemLenW = 3;
  localparam int unsigned StemW   = 32;

  localparam logic [ByteW-1:0]  MaxNameBytesReset = 8'd255;
  localparam logic [CountW-1:0] CountSat          = 9'd256;

  // one input word as it travels from the input stage to the name tracker
  typedef struct packed {
    logic [ByteW-1:0] name_byte;
    logic             has_byte;
    logic             last;
  } pfc_item_t;

endpackage

FILE: hdl/pfc_name_state.sv
// ----------------------------------------------------------------------------
// pfc_name_state
// per-name flags and counters, next-state update and verdict logic
// ----------------------------------------------------------------------------
module pfc_name_state (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pfc_pkg::pfc_item_t             item_i,
  input  logic                           fire_i,
  input  logic [pfc_pkg::ByteW-1:0]      max_name_bytes_i,
  output logic                           safe_o
);

  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDel   = 8'h7F;

  logic [pfc_pkg::CountW-1:0]   count_q, count_d;
  logic                         bad_q, bad_d;
  logic [pfc_pkg::ByteW-1:0]    final_q, final_d;
  logic                         only_dots_q, only_dots_d;
  logic                         dot_seen_q, dot_seen_d;
  logic [pfc_pkg::StemLenW-1:0] stem_len_q, stem_len_d;
  logic [pfc_pkg::StemW-1:0]    stem_q, stem_d;

  function automatic logic forbidden(input logic [7:0] b);
    logic res;
    res = (b < ChSpace) || (b == ChDel) || (b == 8'h2F) || (b == 8'h5C) ||
          (b == 8'h3C) || (b == 8'h3E) || (b == 8'h3A) || (b == 8'h22) ||
          (b == 8'h7C) || (b == 8'h3F) || (b == 8'h2A);
    return res;
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] b);
    logic [7:0] res;
    res = ((b >= 8'h41) && (b <= 8'h5A)) ? (b + 8'h20) : b;
    return res;
  endfunction

  function automatic logic stem_is(input logic [31:0] s, input logic [23:0] w);
    logic res;
    // w holds the word with its first letter in the top byte
    res = (s[7:0] == w[23:16]) && (s[15:8] == w[15:8]) && (s[23:16] == w[7:0]);
    return res;
  endfunction

  function automatic logic device_stem(input logic [2:0] len, input logic [31:0] s);
    logic res;
    res = 1'b0;
    if (len == 3'd3) begin
      res = stem_is(s, "con") || stem_is(s, "prn") || stem_is(s, "aux") ||
            stem_is(s, "nul");
    end else if (len == 3'd4) begin
      res = (stem_is(s, "com") || stem_is(s, "lpt")) &&
            (s[31:24] >= "1") && (s[31:24] <= "9");
    end
    return res;
  endfunction

  // state after taking this word's byte
  always_comb begin
    count_d     = count_q;
    bad_d       = bad_q;
    final_d     = final_q;
    only_dots_d = only_dots_q;
    dot_seen_d  = dot_seen_q;
    stem_len_d  = stem_len_q;
    stem_d      = stem_q;
    if (item_i.has_byte) begin
      if (count_q != pfc_pkg::CountSat) count_d = count_q + 1'b1;
      if (forbidden(item_i.name_byte)) bad_d = 1'b1;
      final_d = item_i.name_byte;
      if (item_i.name_byte != ChDot) only_dots_d = 1'b0;
      if (!dot_seen_q) begin
        if (item_i.name_byte == ChDot) begin
          dot_seen_d = 1'b1;
        end else if (stem_len_q < 3'd5) begin
          if (stem_len_q < 3'd4) begin
            stem_d[{stem_len_q[1:0], 3'b000} +: 8] = fold(item_i.name_byte);
          end
          stem_len_d = stem_len_q + 1'b1;
        end
      end
    end
  end

  // verdict on the name as it stands after this word
  always_comb begin
    safe_o = (count_d != '0) && (count_d <= {1'b0, max_name_bytes_i});
    if (only_dots_d && (count_d <= 9'd2)) safe_o = 1'b0;
    if ((count_d != '0) && ((final_d == ChDot) || (final_d == ChSpace))) safe_o = 1'b0;
    if (bad_d || device_stem(stem_len_d, stem_d)) safe_o = 1'b0;
  end

  // state registers, back to reset values at the end of each name
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      bad_q       <= 1'b0;
      final_q     <= '0;
      only_dots_q <= 1'b1;
      dot_seen_q  <= 1'b0;
      stem_len_q  <= '0;
      stem_q      <= '0;
    end else if (fire_i) begin
      if (item_i.last) begin
        count_q     <= '0;
        bad_q       <= 1'b0;
        final_q     <= '0;
        only_dots_q <= 1'b1;
        dot_seen_q  <= 1'b0;
        stem_len_q  <= '0;
        stem_q      <= '0;
      end else begin
        count_q     <= count_d;
        bad_q       <= bad_d;
        final_q     <= final_d;
        only_dots_q <= only_dots_d;
        dot_seen_q  <= dot_seen_d;
        stem_len_q  <= stem_len_d;
        stem_q      <= stem_d;
      end
    end
  end

endmodule

FILE: hdl/portable_filename_checker_top.sv
// ----------------------------------------------------------------------------
// portable_filename_checker_top
// checks a file-name component, one byte per word, for windows portability
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_stall_o | name_byte_i, has_byte_i, last_i
//  out     | output    | out_valid_o/out_stall_i | safe_o
//  cfg     | input     | cfg_we_i              | cfg_wdata_i (max_name_bytes)
//
//  one word per cycle while no held verdict stalls the input; a name's last
//  word passes the input register, then its verdict the result register
//  reset clears all name state and sets max_name_bytes to 255
//  a held verdict stalls the input stage only when the next word ends a name
// ----------------------------------------------------------------------------
module portable_filename_checker_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] name_byte_i,
  input  logic       has_byte_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       safe_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  logic                         s1_valid_q;
  pfc_pkg::pfc_item_t           s1_item_q;
  logic                         s1_fire;
  logic                         in_fire;
  logic                         out_valid_q;
  logic                         safe_q;
  logic                         verdict;
  logic [pfc_pkg::ByteW-1:0]    max_q;

  // stage one moves unless it ends a name while a verdict is held
  assign s1_fire    = s1_valid_q && !(s1_item_q.last && out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_fire    = in_valid_i && !in_stall_o;

  // length limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= pfc_pkg::MaxNameBytesReset;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q.name_byte <= name_byte_i;
      s1_item_q.has_byte  <= has_byte_i;
      s1_item_q.last      <= last_i;
    end
  end

  pfc_name_state u_name_state (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (s1_item_q),
    .fire_i           (s1_fire),
    .max_name_bytes_i (max_q),
    .safe_o           (verdict)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_item_q.last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_item_q.last) begin
      safe_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign safe_o      = safe_q;

endmodule

FILE: hdl/pfc_checker.sv
// ----------------------------------------------------------------------------
// pfc_checker
// port-level checks of the file-name checker, bound to the top level
// ----------------------------------------------------------------------------
module pfc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       last_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       safe_o
);

  // a stalled verdict holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(safe_o))
    else $error("stalled verdict changed");

  // a name end taken while the output is empty yields a verdict through the input and result registers
  a_verdict_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i && !out_valid_o |=> ##1 out_valid_o)
    else $error("verdict missing after name end");

  // a fresh verdict always traces back to a name end taken earlier on the input
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && last_i, 2))
    else $error("verdict without a name end");

endmodule

bind portable_filename_checker_top pfc_checker u_pfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .last_i      (last_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .safe_o      (safe_o)
);

FILE: sim/portable_filename_checker_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// portable_filename_checker_chk
// watches the name, verdict and limit channels of the file-name checker,
// tracks each name byte by byte, predicts its verdict and compares it with
// every verdict word that leaves the block
// ----------------------------------------------------------------------------
module portable_filename_checker_chk (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [pfc_pkg::ByteW-1:0] name_byte_i,
  input  logic                      has_byte_i,
  input  logic                      last_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic                      safe_i,
  input  logic                      cfg_we_i,
  input  logic [pfc_pkg::ByteW-1:0] cfg_wdata_i,
  output int unsigned               mismatch_cnt_o,
  output int unsigned               verdicts_due_o
);

  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDel   = 8'h7F;
  localparam int unsigned ReportMax = 10;

  // limit register and running view of the current name
  logic [pfc_pkg::ByteW-1:0]    name_limit;
  logic [pfc_pkg::CountW-1:0]   name_len;
  logic                         bad_seen;
  logic [pfc_pkg::ByteW-1:0]    last_char;
  logic                         all_dots;
  logic                         stem_done;
  logic [pfc_pkg::StemLenW-1:0] stem_len;
  logic [pfc_pkg::StemW-1:0]    stem;

  logic verdict_q[$];
  logic expected;

  function automatic logic is_banned(input logic [7:0] b);
    if (b < ChSpace || b == ChDel) return 1'b1;
    case (b)
      "/", "\\", "<", ">", ":", "\"", "|", "?", "*": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'h20 : b;
  endfunction

  // stem bytes sit lowest first, so flip them before comparing with text
  function automatic logic is_device();
    logic [23:0] head;
    head = {stem[7:0], stem[15:8], stem[23:16]};
    if (stem_len == 3)
      return head == "con" || head == "prn" || head == "aux" || head == "nul";
    if (stem_len == 4 && (head == "com" || head == "lpt"))
      return stem[31:24] >= "1" && stem[31:24] <= "9";
    return 1'b0;
  endfunction

  function automatic logic name_verdict();
    logic ok;
    ok = name_len != 0 && name_len <= {1'b0, name_limit};
    if (all_dots && name_len <= 2) ok = 1'b0;
    if (name_len != 0 && (last_char == ChDot || last_char == ChSpace)) ok = 1'b0;
    if (bad_seen || is_device()) ok = 1'b0;
    return ok;
  endfunction

  task automatic clear_name();
    name_len  = '0;
    bad_seen  = 1'b0;
    last_char = '0;
    all_dots  = 1'b1;
    stem_done = 1'b0;
    stem_len  = '0;
    stem      = '0;
  endtask

  task automatic take_byte(input logic [7:0] b);
    if (name_len < pfc_pkg::CountSat) name_len = name_len + 1'b1;
    if (is_banned(b)) bad_seen = 1'b1;
    last_char = b;
    if (b != ChDot) all_dots = 1'b0;
    // stem ends at the first dot; only four folded bytes are kept
    if (!stem_done) begin
      if (b == ChDot) begin
        stem_done = 1'b1;
      end else if (stem_len < 5) begin
        if (stem_len < 4) stem[8*stem_len +: 8] = fold_case(b);
        stem_len = stem_len + 1'b1;
      end
    end
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatch_cnt_o++;
    if (mismatch_cnt_o <= ReportMax)
      $display("%t: %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // compare leaving verdicts first, then fold in limit writes and new words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_limit = pfc_pkg::MaxNameBytesReset;
      clear_name();
      verdict_q.delete();
      mismatch_cnt_o = 0;
      verdicts_due_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          note_mismatch("verdict with none pending", -1, safe_i);
        end else begin
          expected = verdict_q.pop_front();
          if (safe_i !== expected) note_mismatch("safe flag wrong", expected, safe_i);
        end
      end
      if (cfg_we_i) name_limit = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        if (has_byte_i) take_byte(name_byte_i);
        if (last_i) begin
          verdict_q.push_back(name_verdict());
          clear_name();
        end
      end
      verdicts_due_o = verdict_q.size();
    end
  end

endmodule

FILE: sim/portable_filename_checker_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// portable_filename_checker_top_tb
// feeds file names word by word through the checker under a series of length
// limits, with random gaps and receiver stalls, and reports the verdict of
// the companion checker module
// ----------------------------------------------------------------------------
module portable_filename_checker_top_tb;

  typedef logic [7:0] name_q_t[$];

  localparam int          ResetCycles  = 8;
  localparam int          PhaseWords   = 85;
  localparam int          LongHold     = 200;
  localparam int          WatchLimit   = 3000;
  localparam int          SettleCycles = 6;
  localparam logic [7:0]  ChDot        = 8'h2E;
  localparam logic [6*24-1:0] DevNames = {"con", "prn", "aux", "nul", "com", "lpt"};

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [7:0] name_byte_i = 8'h00;
  logic       has_byte_i  = 1'b0;
  logic       last_i      = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       safe_o;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;

  int unsigned mismatch_cnt;
  int unsigned verdicts_due;

  int         words_sent = 0;
  int         quiet_cycles = 0;
  int         hold_asks = 0;
  int         holds_done = 0;
  bit         tx_calm = 1'b0;
  bit         rx_calm = 1'b0;
  int         rx_wait = 0;
  logic [7:0] cur_limit = pfc_pkg::MaxNameBytesReset;

  portable_filename_checker_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .name_byte_i (name_byte_i),
    .has_byte_i  (has_byte_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .safe_o      (safe_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  portable_filename_checker_chk u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .name_byte_i    (name_byte_i),
    .has_byte_i     (has_byte_i),
    .last_i         (last_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .safe_i         (safe_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mismatch_cnt_o (mismatch_cnt),
    .verdicts_due_o (verdicts_due)
  );

  always #4 clk_i = ~clk_i;

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WatchLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // verdict receiver: random stalls per word, calm stretches, long holds
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_asks != holds_done) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(negedge clk_i);
        holds_done++;
      end else if (rx_wait > 0) begin
        out_stall_i <= 1'b1;
        rx_wait--;
      end else begin
        out_stall_i <= 1'b0;
        if (out_valid_o) begin
          if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
          rx_wait = rx_calm ? 0 : $urandom_range(0, 13);
        end
      end
    end
  end

  // one word on the name channel, held until it is taken
  task automatic send_word(input logic [7:0] b, input logic h, input logic l);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 13);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    name_byte_i <= b;
    has_byte_i  <= h;
    last_i      <= l;
    do @(posedge clk_i); while (in_stall_o);
    if (h || l) words_sent++;
  endtask

  // whole name, ended on its last byte or by a bare end marker
  task automatic send_name(input name_q_t nm, input bit bare_end, input int idle_pct);
    bit end_alone;
    end_alone = bare_end || nm.size() == 0;
    for (int i = 0; i < nm.size(); i++) begin
      if ($urandom_range(0, 99) < idle_pct)
        send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_word(nm[i], 1'b1, !end_alone && i == nm.size() - 1);
    end
    if (end_alone) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  function automatic name_q_t from_text(input string s);
    name_q_t nm;
    for (int i = 0; i < s.len(); i++) nm.push_back(s[i]);
    return nm;
  endfunction

  function automatic logic [7:0] any_letter();
    return 8'($urandom_range("a", "z"));
  endfunction

  // random name, weighted toward device stems, dots and length edges
  function automatic name_q_t make_name(input logic [7:0] limit);
    name_q_t    nm;
    logic [23:0] dev;
    logic [7:0] c;
    int         n;
    case ($urandom_range(0, 9))
      0, 1: begin
        dev = DevNames[24*$urandom_range(0, 5) +: 24];
        for (int k = 2; k >= 0; k--) begin
          c = dev[8*k +: 8];
          if ($urandom_range(0, 1)) c = c - 8'h20;
          nm.push_back(c);
        end
        case ($urandom_range(0, 3))
          0: ;
          1: nm.push_back(8'($urandom_range("0", "9")));
          2: nm.push_back(8'($urandom_range(8'h20, 8'h7E)));
          default: nm.push_back(8'($urandom_range("1", "9")));
        endcase
        if ($urandom_range(0, 1)) begin
          nm.push_back(ChDot);
          n = $urandom_range(0, 3);
          repeat (n) nm.push_back(any_letter());
        end
        // leading dot leaves the stem empty
        if ($urandom_range(0, 5) == 0) nm.push_front(ChDot);
      end
      2: begin
        n = $urandom_range(1, 4);
        repeat (n) nm.push_back(ChDot);
      end
      3: begin
        n = $urandom_range(0, 8);
        repeat (n) nm.push_back(8'($urandom_range(0, 255)));
      end
      4: begin
        n = $urandom_range(1, 8);
        repeat (n) nm.push_back($urandom_range(0, 2) == 0 ? ChDot : any_letter());
      end
      5: begin
        if (limit <= 16 || $urandom_range(0, 19) == 0) begin
          n = int'(limit) + $urandom_range(0, 2) - 1;
          if (n < 1) n = 1;
        end else begin
          n = $urandom_range(1, 6);
        end
        repeat (n) nm.push_back(any_letter());
      end
      default: begin
        n = $urandom_range(1, 12);
        repeat (n) nm.push_back(8'($urandom_range(8'h20, 8'h7E)));
        case ($urandom_range(0, 5))
          0: nm.push_back(ChDot);
          1: nm.push_back(8'h20);
          default: ;
        endcase
      end
    endcase
    return nm;
  endfunction

  // drop valid and wait for every verdict plus the pipeline tail
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (verdicts_due != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_limit(input logic [7:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_limit = v;
  endtask

  task automatic run_phase(input logic [7:0] limit, input bit hold, input bit long_name);
    int start;
    int idle_pct;
    name_q_t nm;
    set_limit(limit);
    tx_calm  = hold || $urandom_range(0, 3) == 0;
    idle_pct = $urandom_range(0, 1) ? 10 : 0;
    if (hold) hold_asks++;
    if (long_name) begin
      repeat ($urandom_range(258, 264)) nm.push_back(any_letter());
      send_name(nm, 1'b0, 0);
    end
    start = words_sent;
    while (words_sent - start < PhaseWords) begin
      if (!hold && $urandom_range(0, 30) == 0) tx_calm = !tx_calm;
      send_name(make_name(cur_limit), $urandom_range(0, 4) == 0, idle_pct);
    end
    settle();
  endtask

  initial begin
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed names under the reset limit
    send_name(from_text(""), 1'b1, 0);
    send_name(from_text("."), 1'b0, 0);
    send_name(from_text(".."), 1'b0, 0);
    send_name(from_text("Aux"), 1'b0, 0);
    send_name(from_text("lPt9"), 1'b0, 0);
    send_name(from_text("a "), 1'b0, 0);
    send_name('{8'hFF, 8'h7F}, 1'b0, 0);
    send_name(from_text("x"), 1'b1, 0);
    // dot-led name with an idle word inside it
    send_word(ChDot, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word("n", 1'b1, 1'b0);
    send_word("u", 1'b1, 1'b0);
    send_word("l", 1'b1, 1'b1);
    settle();

    run_phase(8'd1, 1'b0, 1'b0);
    run_phase(8'd0, 1'b0, 1'b0);
    run_phase(8'd3, 1'b1, 1'b0);
    run_phase(8'd255, 1'b0, 1'b1);
    run_phase(8'($urandom_range(1, 255)), 1'b0, 1'b0);
    run_phase(8'd7, 1'b0, 1'b0);
    run_phase(8'($urandom_range(1, 20)), 1'b0, 1'b0);
    run_phase(8'd255, 1'b0, 1'b0);

    if (mismatch_cnt == 0 && verdicts_due == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
